/* sv/spd_pkg.sv */
// Shared types, constants and helpers for the serial packet deframer.
package spd_pkg;

  localparam logic [7:0]  MARK_START    = 8'hAA;
  localparam logic [7:0]  MARK_END      = 8'h55;
  localparam logic [7:0]  TYPE_LONG     = 8'h01;
  localparam logic [7:0]  TYPE_SEIZURE  = 8'h02;
  localparam logic [7:0]  TYPE_BARE     = 8'h05;
  localparam logic [7:0]  TYPE_SHORT_A  = 8'h06;
  localparam logic [7:0]  TYPE_SHORT_B  = 8'h07;
  localparam logic [15:0] TIMEOUT_RESET = 16'd5000;
  localparam logic [15:0] SILENCE_MAX   = 16'hFFFF;
  localparam logic [15:0] ERR_TOTAL_MAX = 16'hFFFF;
  localparam int          ERROR_COUNT_WIDTH_DEF = 16;
  localparam int          QUEUE_DEPTH_DEF       = 2;

  typedef enum logic [2:0] {
    PH_WAIT_START = 3'd0,
    PH_TYPE       = 3'd1,
    PH_PAYLOAD    = 3'd2,
    PH_SUM        = 3'd3,
    PH_END        = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    CMD_TICK     = 3'd0,
    CMD_SEIZURE  = 3'd1,
    CMD_GOOD     = 3'd2,
    CMD_BAD_TYPE = 3'd3,
    CMD_BAD_SUM  = 3'd4,
    CMD_BAD_END  = 3'd5
  } cmd_op_t;

  typedef enum logic [2:0] {
    EV_SEIZURE  = 3'd0,
    EV_GOOD     = 3'd1,
    EV_BAD_TYPE = 3'd2,
    EV_BAD_SUM  = 3'd3,
    EV_BAD_END  = 3'd4,
    EV_FAULT    = 3'd5
  } evt_t;

  typedef struct packed {
    cmd_op_t    op;
    logic [7:0] ptype;
    logic [7:0] lvl;
    logic [7:0] tm;
  } cmd_t;

  typedef struct packed {
    evt_t        evt;
    logic [7:0]  ptype;
    logic [7:0]  lvl;
    logic [7:0]  tm;
    logic [15:0] err_total;
    logic        fault;
  } res_t;

  typedef struct packed {
    logic       ok;
    logic [1:0] len;
  } type_len_t;

  function automatic type_len_t type_length(input logic [7:0] t);
    type_len_t r;
    r.ok  = 1'b1;
    r.len = 2'd0;
    unique case (t)
      TYPE_LONG:    r.len = 2'd3;
      TYPE_SEIZURE: r.len = 2'd2;
      TYPE_BARE:    r.len = 2'd0;
      TYPE_SHORT_A: r.len = 2'd1;
      TYPE_SHORT_B: r.len = 2'd1;
      default:      r.ok  = 1'b0;
    endcase
    return r;
  endfunction

endpackage

/* sv/spd_fifo.sv */
// Small register queue used between front, back and result port.
module spd_fifo
  import spd_pkg::*;
#(
  parameter int W     = 8,
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (!do_push && do_pop) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("queue count above depth");

  a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) || (cnt_r == CW'(DEPTH)) |-> wr_ptr_r == rd_ptr_r)
    else $error("queue pointers disagree with count");

  a_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    full && !do_pop |=> cnt_r == CW'(DEPTH))
    else $error("queue lost a beat while full");

endmodule

/* sv/spd_front.sv */
// Front end: byte parser and item classifier feeding the command queue.
module spd_front
  import spd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       acc,
  input  logic       kind,
  input  logic [7:0] rx_byte,
  output logic       cmd_push,
  output cmd_t       cmd
);

  phase_t     phase_r, phase_nxt;
  logic [7:0] type_r, type_nxt;
  logic [1:0] len_r, len_nxt;
  logic [1:0] pos_r, pos_nxt;
  logic [7:0] xor_r, xor_nxt;
  logic [7:0] st0_r, st0_nxt;
  logic [7:0] st1_r, st1_nxt;
  type_len_t  tl;
  logic [1:0] pos_inc;

  assign tl      = type_length(rx_byte);
  assign pos_inc = pos_r + 2'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_WAIT_START;
      type_r  <= '0;
      len_r   <= '0;
      pos_r   <= '0;
      xor_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      type_r  <= type_nxt;
      len_r   <= len_nxt;
      pos_r   <= pos_nxt;
      xor_r   <= xor_nxt;
    end
  end

  always_ff @(posedge clk) begin
    st0_r <= st0_nxt;
    st1_r <= st1_nxt;
  end

  always_comb begin
    phase_nxt = phase_r;
    type_nxt  = type_r;
    len_nxt   = len_r;
    pos_nxt   = pos_r;
    xor_nxt   = xor_r;
    st0_nxt   = st0_r;
    st1_nxt   = st1_r;
    cmd_push  = 1'b0;
    cmd.op    = CMD_TICK;
    cmd.ptype = '0;
    cmd.lvl   = '0;
    cmd.tm    = '0;
    if (acc) begin
      if (kind) begin
        cmd_push = 1'b1;
      end else begin
        unique case (phase_r)
          PH_WAIT_START: begin
            if (rx_byte == MARK_START) begin
              phase_nxt = PH_TYPE;
              xor_nxt   = '0;
              pos_nxt   = '0;
            end
          end
          PH_TYPE: begin
            type_nxt = rx_byte;
            len_nxt  = tl.len;
            if (!tl.ok) begin
              phase_nxt = PH_WAIT_START;
              cmd_push  = 1'b1;
              cmd.op    = CMD_BAD_TYPE;
              cmd.ptype = rx_byte;
            end else begin
              xor_nxt   = rx_byte;
              pos_nxt   = '0;
              phase_nxt = (tl.len == 2'd0) ? PH_SUM : PH_PAYLOAD;
            end
          end
          PH_PAYLOAD: begin
            if (pos_r == 2'd0) begin
              st0_nxt = rx_byte;
            end
            if (pos_r == 2'd1) begin
              st1_nxt = rx_byte;
            end
            xor_nxt = xor_r ^ rx_byte;
            pos_nxt = pos_inc;
            if (pos_inc >= len_r) begin
              phase_nxt = PH_SUM;
            end
          end
          PH_SUM: begin
            if (rx_byte == xor_r) begin
              phase_nxt = PH_END;
            end else begin
              phase_nxt = PH_WAIT_START;
              cmd_push  = 1'b1;
              cmd.op    = CMD_BAD_SUM;
              cmd.ptype = type_r;
            end
          end
          PH_END: begin
            phase_nxt = PH_WAIT_START;
            cmd_push  = 1'b1;
            cmd.ptype = type_r;
            if (rx_byte != MARK_END) begin
              cmd.op = CMD_BAD_END;
            end else if (type_r == TYPE_SEIZURE) begin
              cmd.op  = CMD_SEIZURE;
              cmd.lvl = st0_r;
              cmd.tm  = st1_r;
            end else begin
              cmd.op = CMD_GOOD;
            end
          end
          default: phase_nxt = PH_WAIT_START;
        endcase
      end
    end
  end

endmodule

/* sv/spd_back.sv */
// Back end: error count, link supervision and result formatting.
module spd_back
  import spd_pkg::*;
#(
  parameter int ERR_W = ERROR_COUNT_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data,
  input  logic        cmd_valid,
  input  cmd_t        cmd,
  output logic        cmd_pop,
  input  logic        res_full,
  output logic        res_push,
  output res_t        res
);

  logic [15:0]      timeout_r;
  logic [15:0]      sil_r, sil_nxt;
  logic [ERR_W-1:0] err_r, err_nxt;
  logic             fault_r, fault_nxt;
  logic [15:0]      sil_inc;

  assign cmd_pop = cmd_valid & ~res_full;
  assign sil_inc = (sil_r != SILENCE_MAX) ? sil_r + 16'd1 : sil_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RESET;
      sil_r     <= '0;
      err_r     <= '0;
      fault_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        timeout_r <= cfg_data;
      end
      sil_r   <= sil_nxt;
      err_r   <= err_nxt;
      fault_r <= fault_nxt;
    end
  end

  always_comb begin
    sil_nxt   = sil_r;
    err_nxt   = err_r;
    fault_nxt = fault_r;
    res_push  = 1'b0;
    res.evt   = EV_FAULT;
    res.ptype = cmd.ptype;
    res.lvl   = '0;
    res.tm    = '0;
    if (cmd_pop) begin
      unique case (cmd.op)
        CMD_TICK: begin
          sil_nxt   = sil_inc;
          res.ptype = '0;
          if (sil_inc >= timeout_r && !fault_r) begin
            fault_nxt = 1'b1;
            res_push  = 1'b1;
          end
        end
        CMD_SEIZURE, CMD_GOOD: begin
          sil_nxt   = '0;
          fault_nxt = 1'b0;
          res_push  = 1'b1;
          if (cmd.op == CMD_SEIZURE) begin
            res.evt = EV_SEIZURE;
            res.lvl = cmd.lvl;
            res.tm  = cmd.tm;
          end else begin
            res.evt = EV_GOOD;
          end
        end
        CMD_BAD_TYPE, CMD_BAD_SUM, CMD_BAD_END: begin
          res_push = 1'b1;
          if (err_r != '1) begin
            err_nxt = err_r + ERR_W'(1);
          end
          priority case (cmd.op)
            CMD_BAD_TYPE: res.evt = EV_BAD_TYPE;
            CMD_BAD_SUM:  res.evt = EV_BAD_SUM;
            default:      res.evt = EV_BAD_END;
          endcase
        end
        default: res_push = 1'b0;
      endcase
    end
    res.fault = fault_nxt;
    if (err_nxt > ERR_W'(ERR_TOTAL_MAX)) begin
      res.err_total = ERR_TOTAL_MAX;
    end else begin
      res.err_total = 16'(err_nxt);
    end
  end

  a_fault_once: assert property (@(posedge clk) disable iff (!rst_n)
    res_push && res.evt == EV_FAULT |-> !fault_r)
    else $error("fault raised while already set");

  a_good_clears: assert property (@(posedge clk) disable iff (!rst_n)
    res_push && (res.evt == EV_GOOD || res.evt == EV_SEIZURE) |=> !fault_r && sil_r == '0)
    else $error("good packet left fault or silence count");

  a_err_mono: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> err_r >= $past(err_r))
    else $error("error count went down");

  a_res_room: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full)
    else $error("result beat pushed into full queue");

endmodule

/* sv/serial_packet_deframer_unit.sv */
// Top level of the serial packet deframer: front parser, command queue, back end, result queue.
// Commands are registered in the command queue and results in the result queue.
// Throughput: one item per cycle; the front takes a beat whenever the command queue has room.
// The back end drains one command per cycle while the result queue has room.
// Reset (rst_n low, synchronous) empties both queues, returns the parser to waiting for
// start, clears error count, silence count and fault, and loads the timeout with 5000.
module serial_packet_deframer_unit
  import spd_pkg::*;
#(
  parameter int ERROR_COUNT_WIDTH = ERROR_COUNT_WIDTH_DEF,
  parameter int QUEUE_DEPTH       = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic        in_kind,
  input  logic [7:0]  in_rx_byte,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [2:0]  out_event_res,
  output logic [7:0]  out_packet_type,
  output logic [7:0]  out_seizure_level,
  output logic [7:0]  out_seizure_time,
  output logic [15:0] out_error_total,
  output logic        out_link_fault,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_timeout_ticks
);

  localparam int CMD_W = $bits(cmd_t);
  localparam int RES_W = $bits(res_t);

  logic             acc;
  logic             cmd_push, cmd_full, cmd_empty, cmd_pop;
  cmd_t             cmd_in, cmd_out;
  logic [CMD_W-1:0] cmd_rdata;
  logic             res_push, res_full;
  res_t             res_in, res_out;
  logic [RES_W-1:0] res_rdata;

  assign cfg_ready = 1'b1;
  assign in_full   = cmd_full;
  assign acc       = in_push & ~cmd_full;
  assign cmd_out   = cmd_t'(cmd_rdata);
  assign res_out   = res_t'(res_rdata);

  spd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .acc      (acc),
    .kind     (in_kind),
    .rx_byte  (in_rx_byte),
    .cmd_push (cmd_push),
    .cmd      (cmd_in)
  );

  spd_fifo #(
    .W     (CMD_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .wdata (cmd_in),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .rdata (cmd_rdata),
    .empty (cmd_empty)
  );

  spd_back #(
    .ERR_W (ERROR_COUNT_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid & cfg_ready),
    .cfg_data  (cfg_timeout_ticks),
    .cmd_valid (~cmd_empty),
    .cmd       (cmd_out),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_in)
  );

  spd_fifo #(
    .W     (RES_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_in),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (res_rdata),
    .empty (out_empty)
  );

  assign out_event_res     = res_out.evt;
  assign out_packet_type   = res_out.ptype;
  assign out_seizure_level = res_out.lvl;
  assign out_seizure_time  = res_out.tm;
  assign out_error_total   = res_out.err_total;
  assign out_link_fault    = res_out.fault;

endmodule
